@@ sv/alle_pkg.sv @@
`timescale 1ns / 1ps
package alle_pkg;

	localparam int SLOTS       = 64;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int VALUE_WIDTH = 32;

	localparam logic       OP_INSERT = 1'b0;
	localparam logic       OP_DELETE = 1'b1;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic                    opcode;
		logic [SLOT_W-1:0]       position;
		logic signed [31:0]      item_value;
	} op_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] first_slot;
		logic [SLOT_W-1:0] last_slot;
		logic [SLOT_W-1:0] count;
	} res_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LINK,
		S_FILL,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic link;
		logic reject;
		logic fill;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic usable;
		logic out_free;
	} sts_t;

	// link value of a slot before its first write
	function automatic logic [SLOT_W-1:0] next_reset(input logic [SLOT_W-1:0] a);
		logic [SLOT_W-1:0] r;
		if (a == '0 || a == SLOT_W'(SLOTS - 1))
			r = '0;
		else
			r = a + 1'b1;
		return r;
	endfunction

endpackage

@@ sv/alle_ctrl.sv @@
`timescale 1ns / 1ps
module alle_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	output logic          op_stall,
	input  alle_pkg::sts_t sts,
	output alle_pkg::cmd_t cmd
);

	alle_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= alle_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			alle_pkg::S_IDLE: begin
				if (op_valid)
					state_d = alle_pkg::S_LINK;
			end
			alle_pkg::S_LINK: begin
				if (sts.usable)
					state_d = alle_pkg::S_FILL;
				else
					state_d = alle_pkg::S_FINISH;
			end
			alle_pkg::S_FILL:
				state_d = alle_pkg::S_FINISH;
			alle_pkg::S_FINISH: begin
				if (sts.out_free)
					state_d = alle_pkg::S_IDLE;
			end
			default:
				state_d = alle_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		op_stall = 1'b1;
		case (state_q)
			alle_pkg::S_IDLE: begin
				op_stall = 1'b0;
				cmd.take = op_valid;
			end
			alle_pkg::S_LINK: begin
				cmd.link   = sts.usable;
				cmd.reject = !sts.usable;
			end
			alle_pkg::S_FILL:
				cmd.fill = 1'b1;
			alle_pkg::S_FINISH:
				cmd.finish = sts.out_free;
			default:
				op_stall = 1'b1;
		endcase
	end

endmodule

@@ sv/alle_dp.sv @@
`timescale 1ns / 1ps
module alle_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  alle_pkg::op_item_t  op_item,
	input  alle_pkg::cmd_t      cmd,
	output alle_pkg::sts_t      sts,
	output logic                res_valid,
	input  logic                res_stall,
	output alle_pkg::res_item_t res_item
);

	localparam int SW = alle_pkg::SLOT_W;
	localparam int N  = alle_pkg::SLOTS;
	localparam int VW = alle_pkg::VALUE_WIDTH;

	// link memories, with written marks standing in for the reset image
	logic [SW-1:0] next_mem [N];
	logic [SW-1:0] prev_mem [N];
	logic [VW-1:0] value_mem [N];
	logic [N-1:0]  next_wr_q;
	logic [N-1:0]  prev_wr_q;
	logic [N-1:0]  used_q;

	logic          op_q;
	logic [SW-1:0] pos_q;
	logic [VW-1:0] val_q;
	logic [SW-1:0] free_q;
	logic [SW-1:0] count_q;
	logic [SW-1:0] head_q;
	logic [SW-1:0] tail_q;
	logic [1:0]    status_q;
	logic [SW-1:0] slot_q;

	logic [SW-1:0] rd_np_q, rd_nf_q, rd_pp_q;
	logic [SW-1:0] ra_np_q, ra_nf_q;
	logic          rv_np_q, rv_nf_q, rv_pp_q;
	logic [SW-1:0] nxt_p, nxt_f, prv_p;

	logic          nw_en, pw_en;
	logic [SW-1:0] nw_addr, nw_data, pw_addr, pw_data;
	logic          res_valid_q;
	alle_pkg::res_item_t res_q;

	// reads are issued as the item is taken
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rd_np_q <= next_mem[op_item.position];
			rd_nf_q <= next_mem[free_q];
			rd_pp_q <= prev_mem[op_item.position];
			ra_np_q <= op_item.position;
			ra_nf_q <= free_q;
			rv_np_q <= next_wr_q[op_item.position];
			rv_nf_q <= next_wr_q[free_q];
			rv_pp_q <= prev_wr_q[op_item.position];
			op_q    <= op_item.opcode;
			pos_q   <= op_item.position;
			val_q   <= VW'(op_item.item_value);
		end
	end

	assign nxt_p = rv_np_q ? rd_np_q : alle_pkg::next_reset(ra_np_q);
	assign nxt_f = rv_nf_q ? rd_nf_q : alle_pkg::next_reset(ra_nf_q);
	assign prv_p = rv_pp_q ? rd_pp_q : '0;

	always_comb begin
		if (op_q == alle_pkg::OP_INSERT)
			sts.usable = used_q[pos_q] && (free_q != '0);
		else
			sts.usable = (pos_q != '0) && used_q[pos_q];
		sts.out_free = !res_valid_q || !res_stall;
	end

	always_comb begin
		nw_en   = cmd.link || cmd.fill;
		pw_en   = cmd.link || cmd.fill;
		nw_addr = '0;
		nw_data = '0;
		pw_addr = '0;
		pw_data = '0;
		if (op_q == alle_pkg::OP_INSERT) begin
			if (cmd.link) begin
				nw_addr = pos_q;
				nw_data = free_q;
				pw_addr = nxt_p;
				pw_data = free_q;
			end else begin
				nw_addr = free_q;
				nw_data = nxt_p;
				pw_addr = free_q;
				pw_data = pos_q;
			end
		end else begin
			if (cmd.link) begin
				nw_addr = prv_p;
				nw_data = nxt_p;
				pw_addr = nxt_p;
				pw_data = prv_p;
			end else begin
				nw_addr = pos_q;
				nw_data = free_q;
				pw_addr = pos_q;
				pw_data = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (nw_en)
			next_mem[nw_addr] <= nw_data;
		if (pw_en)
			prev_mem[pw_addr] <= pw_data;
		if (cmd.fill && op_q == alle_pkg::OP_INSERT)
			value_mem[free_q] <= val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_wr_q   <= '0;
			prev_wr_q   <= '0;
			used_q      <= N'(1);
			free_q      <= SW'(1);
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			status_q    <= alle_pkg::ST_DONE;
			slot_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (nw_en) begin
				next_wr_q[nw_addr] <= 1'b1;
				// sentinel links mirrored for first and last
				if (nw_addr == '0)
					head_q <= nw_data;
			end
			if (pw_en) begin
				prev_wr_q[pw_addr] <= 1'b1;
				if (pw_addr == '0)
					tail_q <= pw_data;
			end
			if (cmd.reject) begin
				slot_q <= '0;
				if (op_q == alle_pkg::OP_INSERT && used_q[pos_q])
					status_q <= alle_pkg::ST_FULL;
				else
					status_q <= alle_pkg::ST_BADPOS;
			end
			if (cmd.fill) begin
				status_q <= alle_pkg::ST_DONE;
				if (op_q == alle_pkg::OP_INSERT) begin
					used_q[free_q] <= 1'b1;
					free_q         <= nxt_f;
					count_q        <= count_q + 1'b1;
					slot_q         <= free_q;
				end else begin
					used_q[pos_q] <= 1'b0;
					free_q        <= pos_q;
					slot_q        <= '0;
					if (count_q != '0)
						count_q <= count_q - 1'b1;
				end
			end
			if (cmd.finish)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.status     <= status_q;
			res_q.slot       <= slot_q;
			res_q.first_slot <= head_q;
			res_q.last_slot  <= tail_q;
			res_q.count      <= count_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

@@ sv/array_linked_list_engine_core.sv @@
`timescale 1ns / 1ps
// result follows the link, fill and finish steps after the item is taken
// rejected items skip the fill step and go from link straight to finish
// a new item is taken only after the last result leaves the finish step, which can
// wait on res_stall; the steps are set by the dependent link reads and writes
// reset: asynchronous, list comes up empty with every slot but 0 on the free chain
module array_linked_list_engine_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	output logic                op_stall,
	input  alle_pkg::op_item_t  op_item,
	output logic                res_valid,
	input  logic                res_stall,
	output alle_pkg::res_item_t res_item
);

	alle_pkg::cmd_t cmd;
	alle_pkg::sts_t sts;

	alle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_stall (op_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	alle_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_item   (op_item),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

	logic                clk;
	logic                arst_n;
	logic                op_valid;
	logic                op_stall;
	alle_pkg::op_item_t  op_item;
	logic                res_valid;
	logic                res_stall;
	alle_pkg::res_item_t res_item;

	array_linked_list_engine_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_stall (op_stall),
		.op_item  (op_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item)
	);

	// shadow copy of the list
	logic [alle_pkg::SLOT_W-1:0] nxt [alle_pkg::SLOTS];
	logic [alle_pkg::SLOT_W-1:0] prv [alle_pkg::SLOTS];
	logic                        in_use [alle_pkg::SLOTS];
	logic [alle_pkg::SLOT_W-1:0] free_top;
	logic [alle_pkg::SLOT_W-1:0] n_used;

	alle_pkg::res_item_t pending_res [$];

	int errors;
	int n_checked;
	int n_ins_ok, n_del_ok, n_badpos, n_full;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_req;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic list_clear();
		for (int i = 0; i < alle_pkg::SLOTS; i++) begin
			nxt[i] = (i + 1 < alle_pkg::SLOTS) ? alle_pkg::SLOT_W'(i + 1) : '0;
			prv[i] = '0;
			in_use[i] = 1'b0;
		end
		nxt[0] = '0;
		in_use[0] = 1'b1;
		free_top = alle_pkg::SLOT_W'(1);
		n_used = '0;
	endtask

	// applies one op to the shadow list and returns the result it should give
	function automatic alle_pkg::res_item_t list_step(input alle_pkg::op_item_t it);
		logic [alle_pkg::SLOT_W-1:0] p;
		logic [alle_pkg::SLOT_W-1:0] into;
		logic [alle_pkg::SLOT_W-1:0] prior;
		logic [alle_pkg::SLOT_W-1:0] after;
		alle_pkg::res_item_t r;
		r = '0;
		r.status = alle_pkg::ST_BADPOS;
		p = it.position;
		if (it.opcode == alle_pkg::OP_INSERT) begin
			if (!in_use[p]) begin
				r.status = alle_pkg::ST_BADPOS;
			end else if (free_top == '0) begin
				r.status = alle_pkg::ST_FULL;
			end else begin
				into = free_top;
				after = nxt[p];
				free_top = nxt[into];
				nxt[p] = into;
				prv[after] = into;
				prv[into] = p;
				nxt[into] = after;
				in_use[into] = 1'b1;
				n_used = n_used + 1'b1;
				r.slot = into;
				r.status = alle_pkg::ST_DONE;
			end
		end else begin
			if (p == '0 || !in_use[p]) begin
				r.status = alle_pkg::ST_BADPOS;
			end else begin
				prior = prv[p];
				after = nxt[p];
				nxt[prior] = after;
				prv[after] = prior;
				prv[p] = '0;
				nxt[p] = free_top;
				in_use[p] = 1'b0;
				free_top = p;
				if (n_used != '0)
					n_used = n_used - 1'b1;
				r.status = alle_pkg::ST_DONE;
			end
		end
		r.first_slot = nxt[0];
		r.last_slot = prv[0];
		r.count = n_used;
		return r;
	endfunction

	task automatic send_op(input logic op, input logic [alle_pkg::SLOT_W-1:0] pos,
			input logic signed [31:0] val);
		alle_pkg::op_item_t it;
		alle_pkg::res_item_t want;
		it.opcode = op;
		it.position = pos;
		it.item_value = val;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			op_valid <= 1'b0;
			@(negedge clk);
		end
		op_valid <= 1'b1;
		op_item <= it;
		@(posedge clk);
		while (op_stall)
			@(posedge clk);
		want = list_step(it);
		pending_res.push_back(want);
		case (want.status)
			alle_pkg::ST_DONE: begin
				if (op == alle_pkg::OP_INSERT)
					n_ins_ok++;
				else
					n_del_ok++;
			end
			alle_pkg::ST_FULL: n_full++;
			default: n_badpos++;
		endcase
	endtask

	// receiver: random stalls, or a long hold-off when one is requested
	initial begin
		int n;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				n = hold_req;
				hold_req = 0;
				res_stall <= 1'b1;
				repeat (n - 1)
					@(negedge clk);
			end else begin
				res_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		alle_pkg::res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			n_checked++;
			if (pending_res.size() == 0) begin
				$error("result item with nothing pending: %p", res_item);
				errors++;
			end else begin
				want = pending_res.pop_front();
				if (res_item.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res_item.status);
					errors++;
				end
				if (res_item.slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, res_item.slot);
					errors++;
				end
				if (res_item.first_slot !== want.first_slot) begin
					$error("first_slot: expected %0d, got %0d",
						want.first_slot, res_item.first_slot);
					errors++;
				end
				if (res_item.last_slot !== want.last_slot) begin
					$error("last_slot: expected %0d, got %0d",
						want.last_slot, res_item.last_slot);
					errors++;
				end
				if (res_item.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, res_item.count);
					errors++;
				end
			end
		end
	end

	function automatic logic [alle_pkg::SLOT_W-1:0] pick_used(input bit with_sentinel);
		logic [alle_pkg::SLOT_W-1:0] cand [$];
		for (int i = 0; i < alle_pkg::SLOTS; i++)
			if (in_use[i] && (with_sentinel || i != 0))
				cand.push_back(alle_pkg::SLOT_W'(i));
		if (cand.size() == 0)
			return '0;
		return cand[$urandom_range(cand.size() - 1)];
	endfunction

	function automatic logic signed [31:0] pick_value();
		logic signed [31:0] v;
		case ($urandom_range(9))
			0: v = 32'sh7fffffff;
			1: v = 32'sh80000000;
			2: v = -32'sd1;
			3: v = '0;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// mostly legal ops on live slots; the rest is arbitrary noise
	task automatic send_random_op(input bit grow);
		logic op;
		if ($urandom_range(99) < 25) begin
			send_op(1'($urandom), alle_pkg::SLOT_W'($urandom), $urandom);
		end else begin
			op = ($urandom_range(99) < (grow ? 85 : 25)) ?
				alle_pkg::OP_INSERT : alle_pkg::OP_DELETE;
			if (n_used == '0)
				op = alle_pkg::OP_INSERT;
			if (op == alle_pkg::OP_INSERT)
				send_op(alle_pkg::OP_INSERT, pick_used(1'b1), pick_value());
			else
				send_op(alle_pkg::OP_DELETE, pick_used(1'b0), pick_value());
		end
	endtask

	task automatic test_directed();
		send_op(alle_pkg::OP_DELETE, '0, '0);
		send_op(alle_pkg::OP_DELETE, alle_pkg::SLOT_W'(5), 32'sh12345678);
		send_op(alle_pkg::OP_INSERT, alle_pkg::SLOT_W'(7), 32'sh1);
		send_op(alle_pkg::OP_INSERT, '0, 32'sh7fffffff);
		send_op(alle_pkg::OP_INSERT, '0, 32'sh80000000);
		send_op(alle_pkg::OP_INSERT, alle_pkg::SLOT_W'(1), -32'sd1);
		send_op(alle_pkg::OP_INSERT, alle_pkg::SLOT_W'(2), '0);
		send_op(alle_pkg::OP_INSERT, alle_pkg::SLOT_W'(63), 32'sh55555555);
		send_op(alle_pkg::OP_DELETE, alle_pkg::SLOT_W'(63), 32'shaaaaaaaa);
		send_op(alle_pkg::OP_DELETE, alle_pkg::SLOT_W'(4), '0);
		// freed slot comes straight back off the free chain
		send_op(alle_pkg::OP_INSERT, alle_pkg::SLOT_W'(3), 32'sh55555555);
		send_op(alle_pkg::OP_DELETE, alle_pkg::SLOT_W'(2), '0);
		send_op(alle_pkg::OP_DELETE, alle_pkg::SLOT_W'(3), '0);
		send_op(alle_pkg::OP_DELETE, alle_pkg::SLOT_W'(3), '0);
		send_op(alle_pkg::OP_INSERT, alle_pkg::SLOT_W'(4), 32'shaaaaaaaa);
		send_op(alle_pkg::OP_DELETE, alle_pkg::SLOT_W'(1), '0);
		send_op(alle_pkg::OP_DELETE, alle_pkg::SLOT_W'(4), '0);
		send_op(alle_pkg::OP_DELETE, alle_pkg::SLOT_W'(5), '0);
		// only slot 3 is left in the list
		send_op(alle_pkg::OP_DELETE, alle_pkg::SLOT_W'(1), -32'sd1);
		send_op(alle_pkg::OP_INSERT, '0, 32'sh0f0f0f0f);
		send_op(alle_pkg::OP_DELETE, pick_used(1'b0), 32'shf0f0f0f0);
	endtask

	task automatic test_full_store();
		while (n_used != alle_pkg::SLOT_W'(alle_pkg::SLOTS - 1))
			send_op(alle_pkg::OP_INSERT, pick_used(1'b1), pick_value());
		send_op(alle_pkg::OP_INSERT, '0, 32'sh7fffffff);
		send_op(alle_pkg::OP_INSERT, alle_pkg::SLOT_W'(63), -32'sd1);
		send_op(alle_pkg::OP_DELETE, pick_used(1'b0), '0);
		send_op(alle_pkg::OP_INSERT, pick_used(1'b1), pick_value());
		send_op(alle_pkg::OP_INSERT, pick_used(1'b1), pick_value());
		while (n_used != '0)
			send_op(alle_pkg::OP_DELETE, pick_used(1'b0), pick_value());
		send_op(alle_pkg::OP_DELETE, alle_pkg::SLOT_W'(63), '0);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 400;
		repeat (24)
			send_random_op(1'b1);
	endtask

	task automatic test_random(input int n_items, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		// alternate growing and shrinking so the store both fills and drains
		for (int i = 0; i < n_items; i++)
			send_random_op(((i / 100) % 2) == 0);
	endtask

	initial begin
		int w;
		arst_n = 1'b0;
		op_valid = 1'b0;
		op_item = '0;
		errors = 0;
		n_checked = 0;
		n_ins_ok = 0;
		n_del_ok = 0;
		n_badpos = 0;
		n_full = 0;
		hold_req = 0;
		send_idle_pct = 12;
		recv_idle_pct = 46;
		list_clear();
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_full_store();
		test_random(600, 12, 46);
		test_backpressure();
		test_random(600, 46, 12);
		test_random(600, 0, 0);

		@(negedge clk);
		op_valid <= 1'b0;
		for (w = 0; w < 20000 && pending_res.size() != 0; w++)
			@(posedge clk);
		if (pending_res.size() != 0) begin
			$error("%0d result items never arrived", pending_res.size());
			errors++;
		end
		repeat (16)
			@(posedge clk);

		$display("checked %0d results: %0d inserts, %0d deletes, %0d unusable positions,",
			n_checked, n_ins_ok, n_del_ok, n_badpos);
		$display("%0d inserts into a full store, under random stalls and a long hold-off",
			n_full);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
sv/alle_pkg.sv
sv/alle_ctrl.sv
sv/alle_dp.sv
sv/array_linked_list_engine_core.sv
test/testbench.sv
